[rtl/sspick_pkg.sv]
// shared types and constants for the screen-space point pick
package sspick_pkg;

  localparam int CoordW = 32;
  localparam int TagW   = 16;
  localparam int DistW  = 20;
  localparam int RowW   = 64;
  localparam int DotW   = 52;
  localparam int WEps   = 1677;
  localparam int DepthEps = 7;
  localparam logic [DistW-1:0] DistMax = 20'hFFFFF;

  // configuration register indexes
  localparam logic [2:0] CfgRowX   = 3'd0;
  localparam logic [2:0] CfgRowY   = 3'd1;
  localparam logic [2:0] CfgRowW   = 3'd2;
  localparam logic [2:0] CfgViewZ  = 3'd3;
  localparam logic [2:0] CfgWidth  = 3'd4;
  localparam logic [2:0] CfgHeight = 3'd5;
  localparam logic [2:0] CfgCursor = 3'd6;
  localparam logic [2:0] CfgLimit  = 3'd7;

  // one queued candidate between front and back
  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic [TagW-1:0]          tag;
    logic                     last;
  } cand_t;

endpackage

[rtl/sspick_queue.sv]
// two-entry queue between front end and back end
module sspick_queue
  import sspick_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  cand_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output logic  empty,
  output cand_t rd_data
);

  cand_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

[rtl/sspick_back.sv]
// back end: projection, divide, square root, best tracking and result register
module sspick_back
  import sspick_pkg::*;
#(
  parameter int TIE_TOL = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [RowW-1:0]          row_x,
  input  logic [RowW-1:0]          row_y,
  input  logic [RowW-1:0]          row_w,
  input  logic [RowW-1:0]          row_z,
  input  logic [12:0]              scr_w,
  input  logic [12:0]              scr_h,
  input  logic [23:0]              cursor,
  input  logic [DistW-1:0]         limit,
  input  logic                     q_empty,
  input  cand_t                    q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_found,
  output logic [TagW-1:0]          out_winner_tag,
  output logic signed [CoordW-1:0] out_winner_x,
  output logic signed [CoordW-1:0] out_winner_y,
  output logic signed [CoordW-1:0] out_winner_z,
  output logic [DistW-1:0]         out_winner_distance,
  output logic signed [CoordW-1:0] out_winner_depth
);

  typedef enum logic [3:0] {
    S_IDLE, S_DOT, S_DIVX, S_DIVY, S_SCR, S_DELTA, S_SQ, S_SQRT, S_DECIDE, S_EMIT
  } state_t;

  state_t state_r;
  cand_t  cur_r;
  logic [1:0] term_r;
  logic signed [DotW-1:0] acc_x_r, acc_y_r, acc_w_r, acc_z_r;
  // shared restoring divider
  logic [DotW:0]      rem_r;
  logic [29:0]        dsh_r;
  logic [30:0]        quo_r;
  logic [4:0]         dcnt_r;
  logic signed [31:0] nx_r, ny_r;
  logic signed [47:0] sx_r, sy_r;
  logic signed [22:0] dx_r, dy_r;
  // square root
  logic [45:0]        sq_v_r, sq_res_r, sq_bit_r;
  logic [DistW-1:0]   dist_r;
  logic signed [31:0] depth_r;
  logic               have_r;
  logic [DistW-1:0]   bdist_r;
  logic signed [31:0] bdepth_r;
  logic [TagW-1:0]    btag_r;
  logic signed [CoordW-1:0] bx_r, by_r, bz_r;

  // one coefficient times one operand
  function automatic logic signed [DotW-1:0] tmul(logic [RowW-1:0] row, logic [1:0] k,
                                                  logic signed [CoordW:0] v);
    logic signed [15:0] c;
    logic signed [48:0] p;
    c = row[{k, 4'b0000} +: 16];
    p = c * v;
    return DotW'(p);
  endfunction

  // clamp a pixel delta to 8192 pixels
  function automatic logic signed [22:0] sat_d(logic signed [47:0] v);
    if (v > 48'sd2097152) return 23'sd2097152;
    if (v < -48'sd2097152) return -23'sd2097152;
    return v[22:0];
  endfunction

  // term select for serial dot products, one multiply per row per cycle
  logic signed [CoordW:0] opnd;
  always_comb begin
    case (term_r)
      2'd0:    opnd = {cur_r.px[CoordW-1], cur_r.px};
      2'd1:    opnd = {cur_r.py[CoordW-1], cur_r.py};
      2'd2:    opnd = {cur_r.pz[CoordW-1], cur_r.pz};
      default: opnd = 33'sd65536;
    endcase
  end

  // divider operands
  logic signed [DotW-1:0] num_sel;
  logic [DotW-1:0] mag;
  logic [DotW:0] wide_w;
  logic [DotW+13:0] mag_ext, w_sh;
  always_comb begin
    num_sel = (state_r == S_DIVY) ? acc_y_r : acc_x_r;
    mag     = num_sel[DotW-1] ? DotW'(-num_sel) : DotW'(num_sel);
    wide_w  = {1'b0, acc_w_r};
    mag_ext = {14'b0, mag};
    w_sh    = {acc_w_r, 14'b0};
  end
  logic [DotW:0] trial;
  assign trial = {rem_r[DotW-1:0], dsh_r[29]};

  logic signed [31:0] ndiv;
  assign ndiv = $signed({1'b0, quo_r});

  // screen mapping products
  logic signed [31:0] ndc_xo, ndc_yo;
  logic signed [45:0] sx_full, sy_full;
  assign ndc_xo  = nx_r + 32'sd65536;
  assign ndc_yo  = 32'sd65536 - ny_r;
  assign sx_full = ndc_xo * $signed({1'b0, scr_w});
  assign sy_full = ndc_yo * $signed({1'b0, scr_h});

  // squared deltas
  logic signed [45:0] dx2, dy2;
  assign dx2 = dx_r * dx_r;
  assign dy2 = dy_r * dy_r;

  // square root step
  logic [45:0] sq_sum;
  assign sq_sum = sq_res_r + sq_bit_r;

  // decision
  logic signed [DistW+1:0] diff;
  logic [DistW+1:0] adiff;
  logic take;
  always_comb begin
    diff  = $signed({2'b00, dist_r}) - $signed({2'b00, bdist_r});
    adiff = diff[DistW+1] ? -diff : diff;
    take  = (dist_r <= limit) &&
            (!have_r ||
             ({2'b00, dist_r} + (DistW+2)'(TIE_TOL) < {2'b00, bdist_r}) ||
             (adiff <= (DistW+2)'(TIE_TOL) &&
              ($signed({depth_r[31], depth_r}) + 33'(DepthEps) <
               $signed({bdepth_r[31], bdepth_r}))));
  end

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  logic signed [DotW:0] negz;
  logic signed [DotW:0] depf;
  assign negz = -$signed({acc_z_r[DotW-1], acc_z_r});
  assign depf = negz >>> 8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      have_r    <= 1'b0;
      bdist_r <= '0; bdepth_r <= '0; btag_r <= '0;
      bx_r <= '0; by_r <= '0; bz_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cur_r   <= q_data;
            term_r  <= 2'd0;
            acc_x_r <= '0; acc_y_r <= '0; acc_w_r <= '0; acc_z_r <= '0;
            state_r <= S_DOT;
          end
        end
        // four terms, one per cycle
        S_DOT: begin
          acc_x_r <= acc_x_r + tmul(row_x, term_r, opnd);
          acc_y_r <= acc_y_r + tmul(row_y, term_r, opnd);
          acc_w_r <= acc_w_r + tmul(row_w, term_r, opnd);
          acc_z_r <= acc_z_r + tmul(row_z, term_r, opnd);
          term_r  <= term_r + 2'd1;
          if (term_r == 2'd3) begin
            state_r <= S_DIVX;
            dcnt_r  <= 5'd0;
          end
        end
        // restoring divide of mag<<16 by w, 30 quotient bits, one per cycle
        S_DIVX, S_DIVY: begin
          if (acc_w_r <= DotW'(WEps)) begin
            state_r <= S_DECIDE;
          end else if (dcnt_r == 5'd0) begin
            if (mag_ext >= w_sh) begin
              quo_r  <= 31'h40000000;
              dcnt_r <= 5'd31;
            end else begin
              rem_r  <= (DotW+1)'(mag >> 14);
              dsh_r  <= {mag[13:0], 16'b0};
              quo_r  <= '0;
              dcnt_r <= 5'd1;
            end
          end else if (dcnt_r == 5'd31) begin
            if (state_r == S_DIVX) begin
              nx_r    <= num_sel[DotW-1] ? -ndiv : ndiv;
              state_r <= S_DIVY;
            end else begin
              ny_r    <= num_sel[DotW-1] ? -ndiv : ndiv;
              state_r <= S_SCR;
            end
            dcnt_r <= 5'd0;
          end else begin
            if (trial >= wide_w) begin
              rem_r <= trial - wide_w;
              quo_r <= {quo_r[29:0], 1'b1};
            end else begin
              rem_r <= trial;
              quo_r <= {quo_r[29:0], 1'b0};
            end
            dsh_r  <= {dsh_r[28:0], 1'b0};
            dcnt_r <= dcnt_r + 5'd1;
          end
        end
        S_SCR: begin
          sx_r    <= 48'(sx_full >>> 9);
          sy_r    <= 48'(sy_full >>> 9);
          state_r <= S_DELTA;
        end
        S_DELTA: begin
          dx_r <= sat_d(sx_r - $signed({28'b0, cursor[11:0], 8'b0}));
          dy_r <= sat_d(sy_r - $signed({28'b0, cursor[23:12], 8'b0}));
          state_r <= S_SQ;
        end
        S_SQ: begin
          sq_v_r   <= $unsigned(dx2) + $unsigned(dy2);
          sq_res_r <= '0;
          sq_bit_r <= 46'd1 << 44;
          state_r  <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_bit_r == '0) begin
            dist_r  <= (sq_res_r > 46'(DistMax)) ? DistMax : sq_res_r[DistW-1:0];
            depth_r <= (depf > 53'sd2147483647) ? 32'sh7FFFFFFF :
                       (depf < -53'sd2147483648) ? 32'sh80000000 : depf[31:0];
            state_r <= S_DECIDE;
          end else begin
            if (sq_v_r >= sq_sum) begin
              sq_v_r   <= sq_v_r - sq_sum;
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end
        end
        S_DECIDE: begin
          if (take && acc_w_r > DotW'(WEps)) begin
            have_r <= 1'b1; bdist_r <= dist_r; bdepth_r <= depth_r;
            btag_r <= cur_r.tag; bx_r <= cur_r.px; by_r <= cur_r.py; bz_r <= cur_r.pz;
          end
          state_r <= cur_r.last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_found <= have_r; out_winner_tag <= btag_r;
            out_winner_x <= bx_r; out_winner_y <= by_r; out_winner_z <= bz_r;
            out_winner_distance <= bdist_r; out_winner_depth <= bdepth_r;
            have_r <= 1'b0; bdist_r <= '0; bdepth_r <= '0; btag_r <= '0;
            bx_r <= '0; by_r <= '0; bz_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_valid && !out_stall && state_r != S_EMIT) out_valid <= 1'b0;
    end
  end

endmodule

[rtl/screen_space_nearest_point_pick.sv]
// Screen-space nearest point pick. Candidates enter a two-entry queue at one
// beat per cycle while it has room, and the input stalls while it is full. The
// back end takes each candidate in turn: a pop, the serial dot products, the two
// divides by clip w on one shared restoring divider (cut short when the ratio
// clamps), screen mapping, deltas and squares, the square root and the decision.
// A candidate whose clip w is too small skips from the dot products straight to
// the decision. A last beat then loads the output register once any earlier
// result held there has been taken.
module screen_space_nearest_point_pick
  import sspick_pkg::*;
#(
  parameter int TIE_TOLERANCE_LSB = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [RowW-1:0]          cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [CoordW-1:0] in_point_x,
  input  logic signed [CoordW-1:0] in_point_y,
  input  logic signed [CoordW-1:0] in_point_z,
  input  logic [TagW-1:0]          in_candidate_tag,
  input  logic                     in_final_point,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_found,
  output logic [TagW-1:0]          out_winner_tag,
  output logic signed [CoordW-1:0] out_winner_x,
  output logic signed [CoordW-1:0] out_winner_y,
  output logic signed [CoordW-1:0] out_winner_z,
  output logic [DistW-1:0]         out_winner_distance,
  output logic signed [CoordW-1:0] out_winner_depth
);

  logic [RowW-1:0] row_x_r, row_y_r, row_w_r, row_z_r;
  logic [12:0] scr_w_r, scr_h_r;
  logic [23:0] cursor_r;
  logic [DistW-1:0] limit_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r <= '0; row_y_r <= '0; row_w_r <= '0; row_z_r <= '0;
      scr_w_r <= 13'd1; scr_h_r <= 13'd1; cursor_r <= '0; limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgRowX:   row_x_r  <= cfg_data;
        CfgRowY:   row_y_r  <= cfg_data;
        CfgRowW:   row_w_r  <= cfg_data;
        CfgViewZ:  row_z_r  <= cfg_data;
        CfgWidth:  scr_w_r  <= cfg_data[12:0];
        CfgHeight: scr_h_r  <= cfg_data[12:0];
        CfgCursor: cursor_r <= cfg_data[23:0];
        CfgLimit:  limit_r  <= cfg_data[DistW-1:0];
        default: ;
      endcase
    end
  end

  // front end: pack the beat into the queue
  cand_t q_in, q_out;
  logic q_full, q_empty, q_pop, q_push;
  assign q_in   = '{px: in_point_x, py: in_point_y, pz: in_point_z,
                    tag: in_candidate_tag, last: in_final_point};
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  sspick_queue u_queue (
    .clk, .rst_n, .wr_en(q_push), .wr_data(q_in), .full(q_full),
    .rd_en(q_pop), .empty(q_empty), .rd_data(q_out)
  );

  sspick_back #(.TIE_TOL(TIE_TOLERANCE_LSB)) u_back (
    .clk, .rst_n,
    .row_x(row_x_r), .row_y(row_y_r), .row_w(row_w_r), .row_z(row_z_r),
    .scr_w(scr_w_r), .scr_h(scr_h_r), .cursor(cursor_r), .limit(limit_r),
    .q_empty, .q_data(q_out), .q_pop,
    .out_valid, .out_stall, .out_found, .out_winner_tag,
    .out_winner_x, .out_winner_y, .out_winner_z,
    .out_winner_distance, .out_winner_depth
  );

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_winner_tag))
    else $error("result changed under stall");
  // nothing found means zero distance
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_winner_distance == '0)
    else $error("empty result carries a distance");
  // no push into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
    else $error("queue overflow");

endmodule
